/* hw/rtl/hes_pkg.sv */
// haptic effect sequencer package: effect and recoil codes, channel control type,
// effect tables for durations and drive levels
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hes_pkg;

    // widths
    localparam int MODE_W      = 3;
    localparam int PHASE_W     = 3;
    localparam int LVL_W       = 8;
    localparam int ELAPSED_W   = 10;
    localparam int DUR_W       = 14;
    localparam int TIME_W_DEF  = 16;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;

    // effect mode codes
    localparam logic [MODE_W-1:0] MODE_TEST  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TIRE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GUN   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BEAT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STEP  = 3'd4;

    // gun recoil phases with special handling
    localparam logic [PHASE_W-1:0] GUN_PHASE_KICK = 3'd2;
    localparam logic [PHASE_W-1:0] GUN_PHASE_END  = 3'd3;

    // trigger thresholds for gun recoil
    localparam logic [LVL_W-1:0] TRIG_RELEASED = 8'd1;
    localparam logic [LVL_W-1:0] TRIG_PULLED   = 8'd32;

    // drive levels, round(fraction * 255)
    localparam logic [LVL_W-1:0] LVL_OFF  = 8'd0;
    localparam logic [LVL_W-1:0] LVL_FULL = 8'd255;
    localparam logic [LVL_W-1:0] LVL_080  = 8'd204;
    localparam logic [LVL_W-1:0] LVL_030  = 8'd77;
    localparam logic [LVL_W-1:0] LVL_020  = 8'd51;
    localparam logic [LVL_W-1:0] LVL_002  = 8'd5;

    // per-channel timer and phase controls
    typedef struct packed {
        logic clear;      // clear phase and timer
        logic phase_rst;  // phase back to 0, timer holds
        logic time_clr;   // timer to 0, phase holds
        logic run;        // accumulate time and advance phase
    } t_chan_ctrl;

    // last valid phase index of the table for a mode
    function automatic logic [PHASE_W-1:0] f_last(input logic [MODE_W-1:0] mode);
        logic [PHASE_W-1:0] last;
        case (mode)
            MODE_TIRE: last = 3'd2;
            MODE_GUN:  last = 3'd3;
            MODE_BEAT: last = 3'd4;
            MODE_STEP: last = 3'd3;
            default:   last = 3'd0;
        endcase
        return last;
    endfunction

    // phase duration in ms, zero outside the table
    function automatic logic [DUR_W-1:0] f_dur(input logic [MODE_W-1:0] mode,
                                               input logic [PHASE_W-1:0] phase);
        logic [DUR_W-1:0] dur;
        dur = '0;
        case (mode)
            MODE_TIRE: begin
                case (phase)
                    3'd0:    dur = 14'd33;
                    3'd1:    dur = 14'd80;
                    3'd2:    dur = 14'd16;
                    default: dur = '0;
                endcase
            end
            MODE_GUN: begin
                case (phase)
                    3'd0:    dur = 14'd20;
                    3'd1:    dur = 14'd10;
                    3'd2:    dur = 14'd90;
                    3'd3:    dur = 14'd10000;
                    default: dur = '0;
                endcase
            end
            MODE_BEAT: begin
                case (phase)
                    3'd0:    dur = 14'd25;
                    3'd1:    dur = 14'd200;
                    3'd2:    dur = 14'd25;
                    3'd3:    dur = 14'd10;
                    3'd4:    dur = 14'd745;
                    default: dur = '0;
                endcase
            end
            MODE_STEP: begin
                case (phase)
                    3'd0:    dur = 14'd25;
                    3'd1:    dur = 14'd600;
                    3'd2:    dur = 14'd25;
                    3'd3:    dur = 14'd600;
                    default: dur = '0;
                endcase
            end
            default: dur = '0;
        endcase
        return dur;
    endfunction

    // left channel level, zero outside the table
    function automatic logic [LVL_W-1:0] f_lvl_left(input logic [MODE_W-1:0] mode,
                                                    input logic [PHASE_W-1:0] phase);
        logic [LVL_W-1:0] lvl;
        lvl = LVL_OFF;
        case (mode)
            MODE_TIRE: lvl = (phase == 3'd0) ? LVL_080  : LVL_OFF;
            MODE_GUN:  lvl = (phase == 3'd0) ? LVL_FULL : LVL_OFF;
            MODE_BEAT: lvl = (phase == 3'd0) ? LVL_020  : LVL_OFF;
            MODE_STEP: lvl = (phase == 3'd0) ? LVL_030  : LVL_OFF;
            default:   lvl = LVL_OFF;
        endcase
        return lvl;
    endfunction

    // right channel level, zero outside the table
    function automatic logic [LVL_W-1:0] f_lvl_right(input logic [MODE_W-1:0] mode,
                                                     input logic [PHASE_W-1:0] phase);
        logic [LVL_W-1:0] lvl;
        lvl = LVL_OFF;
        case (mode)
            MODE_BEAT: begin
                case (phase)
                    3'd2:    lvl = LVL_020;
                    3'd3:    lvl = LVL_002;
                    default: lvl = LVL_OFF;
                endcase
            end
            MODE_STEP: lvl = (phase == 3'd2) ? LVL_030 : LVL_OFF;
            default:   lvl = LVL_OFF;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hes_channel.sv */
// one effect channel: phase index and saturating phase timer
// depends on hes_pkg
`timescale 1ns / 1ps
`default_nettype none

module hes_channel
    import hes_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_W_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_chan_ctrl           i_ctrl,
    input  wire logic [ELAPSED_W-1:0] i_elapsed,
    input  wire logic [DUR_W-1:0]     i_dur,
    input  wire logic [PHASE_W-1:0]   i_last,
    output logic      [PHASE_W-1:0]   o_phase
);

    logic [PHASE_W-1:0]    r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_time, n_time;
    logic [TIME_WIDTH:0]   w_sum;
    logic [TIME_WIDTH-1:0] w_sat;

    // saturating accumulate of elapsed time
    always_comb begin
        w_sum = {1'b0, r_time} + (TIME_WIDTH + 1)'(i_elapsed);
        w_sat = w_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : w_sum[TIME_WIDTH-1:0];
    end

    // next phase and timer
    always_comb begin
        n_phase = r_phase;
        n_time  = r_time;
        if (i_ctrl.clear) begin
            n_phase = '0;
            n_time  = '0;
        end else if (i_ctrl.phase_rst) begin
            n_phase = '0;
        end else if (i_ctrl.time_clr) begin
            n_time = '0;
        end else if (i_ctrl.run) begin
            n_time = w_sat;
            // phase ends once its time strictly exceeds the duration
            if (w_sat > TIME_WIDTH'(i_dur)) begin
                n_phase = (r_phase >= i_last) ? '0 : r_phase + 3'd1;
                n_time  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_time  <= '0;
        end else begin
            r_phase <= n_phase;
            r_time  <= n_time;
        end
    end

    assign o_phase = r_phase;

endmodule

`default_nettype wire

/* hw/rtl/haptic_effect_sequencer.sv */
// haptic effect sequencer top level: input register, effect logic, drive level register
// depends on hes_pkg and hes_channel
//
// usage:
//   slave stream: one transaction per update tick. tdata carries elapsed_ms,
//   left_trigger and right_trigger. master stream: one transaction per tick
//   with the four drive levels low_motor, high_motor, left_actuator,
//   right_actuator.
//   config: i_cfg_we with i_cfg_wdata selects the effect (0 test, 1 flat tire,
//   2 gun recoil, 3 heartbeat, 4 footsteps) and clears phases, timers,
//   recoil state and drive levels. write it only while no tick is in flight.
// path: an accepted input goes through the input register, then the drive level register.
// throughput: one tick per cycle while the master side is not stalled; the effect state
//   is updated combinationally from the input register into the drive level register.
// reset: effect goes to test mode, all state and levels to zero, both
//   streams empty.
// stall: while the master side is stalled the result holds; one more input
//   is taken into the input register, then o_s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module haptic_effect_sequencer
    import hes_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_W_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config
    input  wire logic                  i_cfg_we,
    input  wire logic [MODE_W-1:0]     i_cfg_wdata,
    // slave stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // elapsed_ms [9:0], left_trigger [17:10], right_trigger [25:18], zero fill
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // master stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // low_motor [7:0], high_motor [15:8], left_actuator [23:16],
    // right_actuator [31:24]
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    // recoil state codes
    localparam logic [1:0] RCL_RELEASE = 2'd0;
    localparam logic [1:0] RCL_PULL    = 2'd1;
    localparam logic [1:0] RCL_PLAY    = 2'd2;

    logic                 r_in_valid;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [LVL_W-1:0]     r_ltrig, r_rtrig;
    logic                 r_out_valid;
    logic [MODE_W-1:0]    r_mode;
    logic [1:0]           r_recoil, n_recoil;
    logic [LVL_W-1:0]     r_lvl_low, r_lvl_high, r_lvl_left, r_lvl_right;
    logic [LVL_W-1:0]     n_lvl_low, n_lvl_high, n_lvl_left, n_lvl_right;
    logic                 w_adv;
    logic                 w_in_acc;
    t_chan_ctrl           w_lctrl, w_rctrl;
    logic [PHASE_W-1:0]   w_lphase, w_rphase;

    // handshake
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_elapsed <= i_s_axis_tdata[9:0];
            r_ltrig   <= i_s_axis_tdata[17:10];
            r_rtrig   <= i_s_axis_tdata[25:18];
        end
    end

    // channels
    hes_channel #(.TIME_WIDTH(TIME_WIDTH)) u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_lctrl),
        .i_elapsed (r_elapsed),
        .i_dur     (f_dur(r_mode, w_lphase)),
        .i_last    (f_last(r_mode)),
        .o_phase   (w_lphase)
    );

    hes_channel #(.TIME_WIDTH(TIME_WIDTH)) u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_rctrl),
        .i_elapsed (r_elapsed),
        .i_dur     (f_dur(r_mode, w_rphase)),
        .i_last    (f_last(r_mode)),
        .o_phase   (w_rphase)
    );

    // effect logic for one tick
    always_comb begin
        w_lctrl     = '0;
        w_rctrl     = '0;
        n_recoil    = r_recoil;
        n_lvl_low   = r_lvl_low;
        n_lvl_high  = r_lvl_high;
        n_lvl_left  = r_lvl_left;
        n_lvl_right = r_lvl_right;
        if (i_cfg_we) begin
            w_lctrl.clear = 1'b1;
            w_rctrl.clear = 1'b1;
            n_recoil      = RCL_RELEASE;
            n_lvl_low     = LVL_OFF;
            n_lvl_high    = LVL_OFF;
            n_lvl_left    = LVL_OFF;
            n_lvl_right   = LVL_OFF;
        end else if (w_adv) begin
            case (r_mode)
                MODE_TEST: begin
                    n_lvl_low   = r_ltrig;
                    n_lvl_high  = r_rtrig;
                    n_lvl_left  = r_ltrig;
                    n_lvl_right = r_rtrig;
                end
                MODE_TIRE: begin
                    n_lvl_left  = f_lvl_left(r_mode, w_lphase);
                    w_lctrl.run = 1'b1;
                end
                MODE_GUN: begin
                    case (r_recoil)
                        RCL_PULL: begin
                            if (r_ltrig >= TRIG_PULLED) begin
                                w_lctrl.time_clr = 1'b1;
                                n_recoil         = RCL_PLAY;
                            end
                        end
                        RCL_PLAY: begin
                            n_lvl_left = f_lvl_left(r_mode, w_lphase);
                            n_lvl_low  = (w_lphase == GUN_PHASE_KICK) ? LVL_FULL : LVL_OFF;
                            n_lvl_high = n_lvl_low;
                            if (w_lphase == GUN_PHASE_END) begin
                                w_lctrl.phase_rst = 1'b1;
                                n_recoil          = RCL_RELEASE;
                            end else begin
                                w_lctrl.run = 1'b1;
                            end
                        end
                        default: begin
                            // wait for release, unknown code behaves the same
                            if (r_ltrig <= TRIG_RELEASED) begin
                                n_recoil = RCL_PULL;
                            end
                        end
                    endcase
                end
                MODE_BEAT, MODE_STEP: begin
                    n_lvl_left  = f_lvl_left(r_mode, w_lphase);
                    n_lvl_right = f_lvl_right(r_mode, w_rphase);
                    w_lctrl.run = 1'b1;
                    w_rctrl.run = 1'b1;
                end
                default: begin
                    // unknown effect holds everything
                end
            endcase
        end
    end

    // effect state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TEST;
            r_recoil    <= RCL_RELEASE;
            r_out_valid <= 1'b0;
            r_lvl_low   <= LVL_OFF;
            r_lvl_high  <= LVL_OFF;
            r_lvl_left  <= LVL_OFF;
            r_lvl_right <= LVL_OFF;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_recoil    <= n_recoil;
            r_lvl_low   <= n_lvl_low;
            r_lvl_high  <= n_lvl_high;
            r_lvl_left  <= n_lvl_left;
            r_lvl_right <= n_lvl_right;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_lvl_right, r_lvl_left, r_lvl_high, r_lvl_low};

    // recoil state machine never reaches the unused code
    a_recoil_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recoil != 2'd3)
        else $error("recoil state reached unused code");

    // phases stay inside the largest table
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lphase <= 3'd4 && w_rphase <= 3'd4)
        else $error("phase index beyond table");

    // effect write clears levels and phases
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (o_m_axis_tdata == '0 && w_lphase == '0 && w_rphase == '0))
        else $error("effect write did not clear state");

    // test mode mirrors triggers onto motors and actuators
    a_test_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !i_cfg_we && r_mode == MODE_TEST)
            |=> (r_lvl_low == r_lvl_left && r_lvl_high == r_lvl_right))
        else $error("test mode levels mismatch");

endmodule

`default_nettype wire
